/* rtl/sorted_dedup_vertex_queue_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted vertex queue
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_DEDUP_VERTEX_QUEUE_MACROS_SVH
`define SORTED_DEDUP_VERTEX_QUEUE_MACROS_SVH

// Same-cycle implication.
`define SDVQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sdvq assertion failed");

// Next-cycle implication.
`define SDVQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sdvq assertion failed");

`endif

/* rtl/sdvq_pkg.sv */
// ----------------------------------------------------------------------------
// sdvq_pkg
// Types and codes shared by the vertex queue top level and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdvq_pkg;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_SORTED = 2'd1;
    localparam logic [1:0] KIND_POP    = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_PRESENT   = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_RANGE     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;
    localparam logic [2:0] ST_POPPED    = 3'd6;

    localparam int FIELD_BITS = 16;

    // Command broadcast to every cell.
    typedef struct packed {
        logic capture;  // compare the incoming word against the stored entry
        logic sorted;   // incoming word is a sorted insert
        logic pop;      // shift every entry one place toward the head
        logic ins;      // open a gap at the insert point and fill it
    } t_cell_cmd;

endpackage

/* rtl/sdvq_cell.sv */
// ----------------------------------------------------------------------------
// sdvq_cell
// One queue slot: holds a vertex and its priority, compares them against an
// incoming word, and shifts to or from its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdvq_cell #(
    parameter int VW       = 16,
    parameter int CW       = 7,
    parameter int CELL_IDX = 0
) (
    input  logic                                  i_clk,
    input  sdvq_pkg::t_cell_cmd                   i_cmd,
    input  logic [CW-1:0]                         i_count,
    input  logic [VW-1:0]                         i_cmp_vtx,
    input  logic signed [sdvq_pkg::FIELD_BITS-1:0] i_cmp_pri,
    input  logic [VW-1:0]                         i_new_vtx,
    input  logic signed [sdvq_pkg::FIELD_BITS-1:0] i_new_pri,
    input  logic [VW-1:0]                         i_left_vtx,
    input  logic signed [sdvq_pkg::FIELD_BITS-1:0] i_left_pri,
    input  logic [VW-1:0]                         i_right_vtx,
    input  logic signed [sdvq_pkg::FIELD_BITS-1:0] i_right_pri,
    input  logic                                  i_stop_in,
    output logic                                  o_stop_out,
    output logic                                  o_dup,
    output logic                                  o_present,
    output logic [VW-1:0]                         o_vtx,
    output logic signed [sdvq_pkg::FIELD_BITS-1:0] o_pri
);

    logic [VW-1:0]                          r_vtx, n_vtx;
    logic signed [sdvq_pkg::FIELD_BITS-1:0] r_pri, n_pri;
    logic                                   r_match;
    logic                                   r_stop;
    logic                                   w_valid;

    assign w_valid = (i_count > CW'(CELL_IDX));

    // Flags are taken when the word is accepted; the entry cannot change
    // before the word commits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_match <= w_valid && (r_vtx == i_cmp_vtx);
            r_stop  <= !w_valid || (i_cmd.sorted && (r_pri < i_cmp_pri));
        end
    end

    always_comb begin
        n_vtx = r_vtx;
        n_pri = r_pri;
        if (i_cmd.pop) begin
            n_vtx = i_right_vtx;
            n_pri = i_right_pri;
        end else if (i_cmd.ins) begin
            if (i_stop_in) begin
                n_vtx = i_left_vtx;
                n_pri = i_left_pri;
            end else if (r_stop) begin
                n_vtx = i_new_vtx;
                n_pri = i_new_pri;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vtx <= n_vtx;
        r_pri <= n_pri;
    end

    assign o_stop_out = i_stop_in || r_stop;
    assign o_dup      = r_match;
    // Only entries scanned before the first lower priority count as present.
    assign o_present  = r_match && !r_stop && !i_stop_in;
    assign o_vtx      = r_vtx;
    assign o_pri      = r_pri;

endmodule

/* rtl/sorted_dedup_vertex_queue.sv */
// ----------------------------------------------------------------------------
// sorted_dedup_vertex_queue
// Bounded ordered vertex queue with duplicate check, built as a row of cells.
// ----------------------------------------------------------------------------
// Each word goes in two steps: on acceptance, all cells compare their entry
// against the incoming vertex and priority in parallel; on commit, the
// insert point resolves along the chain of cells, the queue shifts, and the
// result word is loaded into the output register. No word is taken until the
// last result is loaded, and a stalled output side holds the commit. Kinds:
// 0 append at tail unless already queued, 1 insert in front of the first
// lower priority, 2 pop the head, 3 refused. A vertex above the limit
// register is refused.
`timescale 1ns / 1ps

module sorted_dedup_vertex_queue #(
    parameter int QUEUE_DEPTH = 64,
    parameter int VERTEX_BITS = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_we,
    input  logic [sdvq_pkg::FIELD_BITS-1:0]               i_cfg_wdata,
    input  logic                                          i_in_valid,
    output logic                                          o_in_stall,
    input  logic [1:0]                                    i_in_kind,
    input  logic [sdvq_pkg::FIELD_BITS-1:0]               i_in_vertex,
    input  logic signed [sdvq_pkg::FIELD_BITS-1:0]        i_in_priority_req,
    output logic                                          o_out_valid,
    input  logic                                          i_out_stall,
    output logic [2:0]                                    o_out_status,
    output logic [sdvq_pkg::FIELD_BITS-1:0]               o_out_popped_vertex,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]              o_out_queue_length
);

    `include "sorted_dedup_vertex_queue_macros.svh"

    localparam int VW = (VERTEX_BITS < sdvq_pkg::FIELD_BITS) ? VERTEX_BITS
                                                            : sdvq_pkg::FIELD_BITS;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int FW = sdvq_pkg::FIELD_BITS;

    logic [FW-1:0]        r_limit;
    logic                 r_busy;
    logic [1:0]           r_kind;
    logic                 r_range;
    logic [VW-1:0]        r_vtx;
    logic signed [FW-1:0] r_pri;
    logic [CW-1:0]        r_count, n_count;

    logic                 r_out_valid;
    logic [2:0]           r_status, n_status;
    logic [FW-1:0]        r_popped, n_popped;
    logic [CW-1:0]        r_len;

    logic                 w_in_acc;
    logic                 w_commit;
    logic [VW-1:0]        w_in_vtx;
    logic                 w_full;
    logic                 w_do_pop;
    logic                 w_do_ins;
    sdvq_pkg::t_cell_cmd  w_cmd;

    logic [VW-1:0]        w_vtx  [QUEUE_DEPTH];
    logic signed [FW-1:0] w_pri  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0] w_stop;
    logic [QUEUE_DEPTH-1:0] w_dup;
    logic [QUEUE_DEPTH-1:0] w_pres;

    assign w_in_vtx = i_in_vertex[VW-1:0];
    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_commit = r_busy && (!r_out_valid || !i_out_stall);
    assign w_full   = (r_count == CW'(QUEUE_DEPTH));

    // No word is taken while reset is held.
    assign o_in_stall = r_busy || !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '1;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_in_acc) begin
            r_busy <= 1'b1;
        end else if (w_commit) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind  <= i_in_kind;
            r_vtx   <= w_in_vtx;
            r_pri   <= i_in_priority_req;
            r_range <= (FW'(w_in_vtx) > r_limit);
        end
    end

    // Decide the outcome from the flags the cells captured.
    always_comb begin
        n_status = sdvq_pkg::ST_RANGE;
        n_popped = '0;
        n_count  = r_count;
        w_do_pop = 1'b0;
        w_do_ins = 1'b0;
        case (r_kind)
            sdvq_pkg::KIND_POP: begin
                if (r_count == '0) begin
                    n_status = sdvq_pkg::ST_EMPTY;
                end else begin
                    n_status = sdvq_pkg::ST_POPPED;
                    n_popped = FW'(w_vtx[0]);
                    n_count  = r_count - CW'(1);
                    w_do_pop = 1'b1;
                end
            end
            sdvq_pkg::KIND_APPEND: begin
                if (r_range) begin
                    n_status = sdvq_pkg::ST_RANGE;
                end else if (|w_dup) begin
                    n_status = sdvq_pkg::ST_DUPLICATE;
                end else if (w_full) begin
                    n_status = sdvq_pkg::ST_FULL;
                end else begin
                    n_status = sdvq_pkg::ST_INSERTED;
                    n_count  = r_count + CW'(1);
                    w_do_ins = 1'b1;
                end
            end
            sdvq_pkg::KIND_SORTED: begin
                if (r_range) begin
                    n_status = sdvq_pkg::ST_RANGE;
                end else if (|w_pres) begin
                    n_status = sdvq_pkg::ST_PRESENT;
                end else if (w_full) begin
                    n_status = sdvq_pkg::ST_FULL;
                end else begin
                    n_status = sdvq_pkg::ST_INSERTED;
                    n_count  = r_count + CW'(1);
                    w_do_ins = 1'b1;
                end
            end
            default: begin
                n_status = sdvq_pkg::ST_RANGE;
            end
        endcase
    end

    assign w_cmd.capture = w_in_acc;
    assign w_cmd.sorted  = (i_in_kind == sdvq_pkg::KIND_SORTED);
    assign w_cmd.pop     = w_commit && w_do_pop;
    assign w_cmd.ins     = w_commit && w_do_ins;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_commit) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_status <= n_status;
            r_popped <= n_popped;
            r_len    <= n_count;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_status        = r_status;
    assign o_out_popped_vertex = r_popped;
    assign o_out_queue_length  = r_len;

    assign w_stop[0] = 1'b0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic [VW-1:0]        w_lv;
        logic signed [FW-1:0] w_lp;
        logic [VW-1:0]        w_rv;
        logic signed [FW-1:0] w_rp;

        if (g == 0) begin : g_head
            assign w_lv = '0;
            assign w_lp = '0;
        end else begin : g_mid_l
            assign w_lv = w_vtx[g-1];
            assign w_lp = w_pri[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_rv = w_vtx[g];
            assign w_rp = w_pri[g];
        end else begin : g_mid_r
            assign w_rv = w_vtx[g+1];
            assign w_rp = w_pri[g+1];
        end

        sdvq_cell #(
            .VW       (VW),
            .CW       (CW),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_count     (r_count),
            .i_cmp_vtx   (w_in_vtx),
            .i_cmp_pri   (i_in_priority_req),
            .i_new_vtx   (r_vtx),
            .i_new_pri   (r_pri),
            .i_left_vtx  (w_lv),
            .i_left_pri  (w_lp),
            .i_right_vtx (w_rv),
            .i_right_pri (w_rp),
            .i_stop_in   (w_stop[g]),
            .o_stop_out  (w_stop[g+1]),
            .o_dup       (w_dup[g]),
            .o_present   (w_pres[g]),
            .o_vtx       (w_vtx[g]),
            .o_pri       (w_pri[g])
        );
    end

    `SDVQ_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(QUEUE_DEPTH))
    `SDVQ_ASSERT_NXT(a_pop_dec, w_commit && w_do_pop, r_count == $past(r_count) - CW'(1))
    `SDVQ_ASSERT_NXT(a_ins_inc, w_commit && w_do_ins, r_count == $past(r_count) + CW'(1))
    `SDVQ_ASSERT_IMP(a_popped_zero, r_out_valid && (r_status != sdvq_pkg::ST_POPPED),
                     r_popped == '0)
    `SDVQ_ASSERT_IMP(a_inserted_len, r_out_valid && (r_status == sdvq_pkg::ST_INSERTED),
                     r_len != '0)
    `SDVQ_ASSERT_IMP(a_ins_has_slot, w_commit && w_do_ins, w_stop[QUEUE_DEPTH])

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sorted vertex queue
// Drives append, sorted-insert, pop and unused-kind words through the
// valid/stall ports with random idling on both sides. Every result word is
// compared against a table answer or a shadow copy of the queue that the
// bench keeps in step with each accepted word. A directed table comes first,
// then random traffic under several vertex limits.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_PERIOD      = 10;
    localparam int QUEUE_DEPTH     = 64;
    localparam int WORDS_PER_LIMIT = 250;
    localparam int SEGMENT_WORDS   = 50;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 1000;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] popped_vertex;
        logic [6:0]  queue_length;
    } t_outcome;

    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        vertex;
        logic signed [15:0] prio;
        logic               has_answer;
        logic [2:0]         status;
        logic [15:0]        popped;
        logic [6:0]         length;
    } t_directed_row;

    // Runs under a limit of 65534 so that 65535 is the first refused vertex.
    localparam t_directed_row DIRECTED_ROWS [25] = '{
        '{sdvq_pkg::KIND_POP,    16'd0,     16'sh0000, 1'b1, sdvq_pkg::ST_EMPTY,     16'd0, 7'd0},
        '{sdvq_pkg::KIND_APPEND, 16'd0,     16'sh8000, 1'b1, sdvq_pkg::ST_INSERTED,  16'd0, 7'd1},
        '{sdvq_pkg::KIND_APPEND, 16'd0,     16'sh0000, 1'b1, sdvq_pkg::ST_DUPLICATE, 16'd0, 7'd1},
        '{sdvq_pkg::KIND_APPEND, 16'd65534, 16'sh7FFF, 1'b1, sdvq_pkg::ST_INSERTED,  16'd0, 7'd2},
        '{sdvq_pkg::KIND_APPEND, 16'd65534, 16'sh0005, 1'b1, sdvq_pkg::ST_DUPLICATE, 16'd0, 7'd2},
        '{sdvq_pkg::KIND_APPEND, 16'd65535, 16'sh0000, 1'b1, sdvq_pkg::ST_RANGE,     16'd0, 7'd2},
        '{sdvq_pkg::KIND_SORTED, 16'd65535, 16'sh7FFF, 1'b1, sdvq_pkg::ST_RANGE,     16'd0, 7'd2},
        '{sdvq_pkg::KIND_SORTED, 16'd7,     16'sh7FFF, 1'b0, sdvq_pkg::ST_INSERTED,  16'd0, 7'd0},
        '{sdvq_pkg::KIND_SORTED, 16'd65534, 16'sh7FFF, 1'b0, sdvq_pkg::ST_INSERTED,  16'd0, 7'd0},
        '{sdvq_pkg::KIND_SORTED, 16'd7,     16'sh0064, 1'b1, sdvq_pkg::ST_PRESENT,   16'd0, 7'd4},
        '{sdvq_pkg::KIND_SORTED, 16'd7,     16'sh7FFF, 1'b1, sdvq_pkg::ST_PRESENT,   16'd0, 7'd4},
        '{sdvq_pkg::KIND_UNUSED, 16'd7,     16'sh0000, 1'b1, sdvq_pkg::ST_RANGE,     16'd0, 7'd4},
        '{sdvq_pkg::KIND_SORTED, 16'd20,    16'sh0000, 1'b0, sdvq_pkg::ST_INSERTED,  16'd0, 7'd0},
        '{sdvq_pkg::KIND_SORTED, 16'd21,    16'sh0000, 1'b0, sdvq_pkg::ST_INSERTED,  16'd0, 7'd0},
        '{sdvq_pkg::KIND_SORTED, 16'd22,    16'sh0000, 1'b0, sdvq_pkg::ST_INSERTED,  16'd0, 7'd0},
        '{sdvq_pkg::KIND_SORTED, 16'd0,     16'sh8000, 1'b0, sdvq_pkg::ST_INSERTED,  16'd0, 7'd0},
        '{sdvq_pkg::KIND_POP,    16'd0,     16'sh0000, 1'b0, sdvq_pkg::ST_INSERTED,  16'd0, 7'd0},
        '{sdvq_pkg::KIND_POP,    16'd0,     16'sh0000, 1'b0, sdvq_pkg::ST_INSERTED,  16'd0, 7'd0},
        '{sdvq_pkg::KIND_POP,    16'd0,     16'sh0000, 1'b0, sdvq_pkg::ST_INSERTED,  16'd0, 7'd0},
        '{sdvq_pkg::KIND_POP,    16'd0,     16'sh0000, 1'b0, sdvq_pkg::ST_INSERTED,  16'd0, 7'd0},
        '{sdvq_pkg::KIND_POP,    16'd0,     16'sh0000, 1'b0, sdvq_pkg::ST_INSERTED,  16'd0, 7'd0},
        '{sdvq_pkg::KIND_POP,    16'd0,     16'sh0000, 1'b0, sdvq_pkg::ST_INSERTED,  16'd0, 7'd0},
        '{sdvq_pkg::KIND_POP,    16'd0,     16'sh0000, 1'b0, sdvq_pkg::ST_INSERTED,  16'd0, 7'd0},
        '{sdvq_pkg::KIND_POP,    16'd0,     16'sh0000, 1'b1, sdvq_pkg::ST_EMPTY,     16'd0, 7'd0},
        '{sdvq_pkg::KIND_SORTED, 16'd65534, 16'sh8000, 1'b0, sdvq_pkg::ST_INSERTED,  16'd0, 7'd0}
    };

    localparam logic [15:0] LIMIT_STEPS [5] = '{16'd0, 16'd40, 16'd65535, 16'd1000, 16'd32767};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [15:0]        cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic [1:0]         in_kind = sdvq_pkg::KIND_APPEND;
    logic [15:0]        in_vertex = '0;
    logic signed [15:0] in_prio = '0;
    logic               out_stall = 1'b0;
    wire                in_stall;
    wire                out_valid;
    wire [2:0]          out_status;
    wire [15:0]         out_popped;
    wire [6:0]          out_length;

    // Shadow copy of the queue contents and the limit register.
    logic [15:0]        shadow_vertex [QUEUE_DEPTH];
    logic signed [15:0] shadow_prio [QUEUE_DEPTH];
    int                 shadow_count = 0;
    logic [15:0]        shadow_limit = 16'd65535;
    int                 deepest_queue = 0;

    t_outcome pending_outcomes [$];
    int       mismatch_count = 0;
    int       words_sent = 0;
    int       results_checked = 0;
    int       limit_writes = 0;
    int       status_tally [8];
    bit       calm_stretch = 1'b0;

    sorted_dedup_vertex_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .VERTEX_BITS(16)
    ) dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_in_kind          (in_kind),
        .i_in_vertex        (in_vertex),
        .i_in_priority_req  (in_prio),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_out_status       (out_status),
        .o_out_popped_vertex(out_popped),
        .o_out_queue_length (out_length)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void insert_entry(input int pos, input logic [15:0] vtx,
                                         input logic signed [15:0] prio);
        for (int i = shadow_count; i > pos; i--) begin
            shadow_vertex[i] = shadow_vertex[i - 1];
            shadow_prio[i]   = shadow_prio[i - 1];
        end
        shadow_vertex[pos] = vtx;
        shadow_prio[pos]   = prio;
        shadow_count++;
    endfunction

    function automatic t_outcome apply_queue_op(input logic [1:0] kind, input logic [15:0] vtx,
                                                input logic signed [15:0] prio);
        t_outcome res;
        int       pos;
        bit       met;
        res = '0;
        pos = 0;
        met = 1'b0;
        if (kind == sdvq_pkg::KIND_POP) begin
            if (shadow_count == 0) begin
                res.status = sdvq_pkg::ST_EMPTY;
            end else begin
                res.popped_vertex = shadow_vertex[0];
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_vertex[i - 1] = shadow_vertex[i];
                    shadow_prio[i - 1]   = shadow_prio[i];
                end
                shadow_count--;
                res.status = sdvq_pkg::ST_POPPED;
            end
        end else if (kind == sdvq_pkg::KIND_UNUSED || vtx > shadow_limit) begin
            res.status = sdvq_pkg::ST_RANGE;
        end else if (kind == sdvq_pkg::KIND_APPEND) begin
            for (int i = 0; i < shadow_count; i++)
                if (shadow_vertex[i] == vtx)
                    met = 1'b1;
            if (met) begin
                res.status = sdvq_pkg::ST_DUPLICATE;
            end else if (shadow_count >= QUEUE_DEPTH) begin
                res.status = sdvq_pkg::ST_FULL;
            end else begin
                insert_entry(shadow_count, vtx, prio);
                res.status = sdvq_pkg::ST_INSERTED;
            end
        end else begin
            // Only the run of entries with priority at or above the new one is
            // searched for the same vertex; a copy further back is allowed.
            while (!met && pos < shadow_count && shadow_prio[pos] >= prio) begin
                if (shadow_vertex[pos] == vtx)
                    met = 1'b1;
                else
                    pos++;
            end
            if (met) begin
                res.status = sdvq_pkg::ST_PRESENT;
            end else if (shadow_count >= QUEUE_DEPTH) begin
                res.status = sdvq_pkg::ST_FULL;
            end else begin
                insert_entry(pos, vtx, prio);
                res.status = sdvq_pkg::ST_INSERTED;
            end
        end
        res.queue_length = 7'(shadow_count);
        if (shadow_count > deepest_queue)
            deepest_queue = shadow_count;
        return res;
    endfunction

    // Called right after a rising edge. A zero gap keeps valid high into the
    // next word, so valid is never dropped and raised in the same step.
    task automatic issue_word(input logic [1:0] kind, input logic [15:0] vtx,
                              input logic signed [15:0] prio, input bit has_answer,
                              input t_outcome answer);
        int       gap;
        t_outcome predicted;
        gap = calm_stretch ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_kind   <= kind;
        in_vertex <= vtx;
        in_prio   <= prio;
        do @(posedge clk); while (in_stall);
        predicted = apply_queue_op(kind, vtx, prio);
        pending_outcomes.push_back(has_answer ? answer : predicted);
        words_sent++;
    endtask

    task automatic write_vertex_limit(input logic [15:0] value);
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        shadow_limit = value;
        limit_writes++;
    endtask

    initial begin : result_checker
        t_outcome want;
        int       stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                results_checked++;
                if (pending_outcomes.size() == 0) begin
                    $error("result word with no expectation pending: status %0d", out_status);
                    mismatch_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    status_tally[want.status]++;
                    if (out_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_status);
                        mismatch_count++;
                    end
                    if (out_popped !== want.popped_vertex) begin
                        $error("popped_vertex: expected %0d, got %0d",
                               want.popped_vertex, out_popped);
                        mismatch_count++;
                    end
                    if (out_length !== want.queue_length) begin
                        $error("queue_length: expected %0d, got %0d",
                               want.queue_length, out_length);
                        mismatch_count++;
                    end
                end
                stall_left = calm_stretch ? 0 : $urandom_range(0, 19);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timed out after %0d cycles with no word moving.", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        t_outcome           row_answer;
        int                 mode;
        int                 roll;
        logic [1:0]         kind;
        logic [15:0]        vtx;
        logic signed [15:0] prio;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_vertex_limit(16'd65534);
        foreach (DIRECTED_ROWS[r]) begin
            row_answer.status        = DIRECTED_ROWS[r].status;
            row_answer.popped_vertex = DIRECTED_ROWS[r].popped;
            row_answer.queue_length  = DIRECTED_ROWS[r].length;
            issue_word(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].vertex, DIRECTED_ROWS[r].prio,
                       DIRECTED_ROWS[r].has_answer, row_answer);
        end

        row_answer = '0;
        foreach (LIMIT_STEPS[s]) begin
            write_vertex_limit(LIMIT_STEPS[s]);
            for (int n = 0; n < WORDS_PER_LIMIT; n++) begin
                // Each segment picks at random among filling toward full,
                // draining toward empty and a mix; some run with no idling at all.
                if (n % SEGMENT_WORDS == 0) begin
                    roll = $urandom_range(0, 4);
                    mode = (roll < 2) ? MODE_FILL : (roll < 3) ? MODE_DRAIN : MODE_MIX;
                    calm_stretch = ($urandom_range(0, 3) == 0);
                end
                roll = $urandom_range(0, 99);
                case (mode)
                    MODE_FILL: begin
                        kind = (roll < 6) ? sdvq_pkg::KIND_POP :
                               (roll < 8) ? sdvq_pkg::KIND_UNUSED :
                               (roll < 54) ? sdvq_pkg::KIND_APPEND : sdvq_pkg::KIND_SORTED;
                    end
                    MODE_DRAIN: begin
                        kind = (roll < 65) ? sdvq_pkg::KIND_POP :
                               (roll < 67) ? sdvq_pkg::KIND_UNUSED :
                               (roll < 83) ? sdvq_pkg::KIND_APPEND : sdvq_pkg::KIND_SORTED;
                    end
                    default: begin
                        kind = (roll < 35) ? sdvq_pkg::KIND_POP :
                               (roll < 38) ? sdvq_pkg::KIND_UNUSED :
                               (roll < 68) ? sdvq_pkg::KIND_APPEND : sdvq_pkg::KIND_SORTED;
                    end
                endcase

                // Small vertex numbers collide often; values around the limit
                // probe the range check from both sides.
                roll = $urandom_range(0, 99);
                if (roll < 30)
                    vtx = 16'($urandom_range(0, 15));
                else if (roll < 50)
                    vtx = 16'(shadow_limit + $urandom_range(0, 2) - 1);
                else if (roll < 90)
                    vtx = 16'($urandom_range(0, shadow_limit));
                else
                    vtx = 16'($urandom_range(0, 65535));

                // A narrow band of priorities makes ties common.
                roll = $urandom_range(0, 99);
                if (roll < 40)
                    prio = 16'($urandom_range(0, 65535));
                else if (roll < 80)
                    prio = 16'(16'hFFFE + $urandom_range(0, 3));
                else if (roll < 90)
                    prio = 16'sh7FFF;
                else
                    prio = 16'sh8000;

                issue_word(kind, vtx, prio, 1'b0, row_answer);
            end
        end

        calm_stretch = 1'b0;
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d words (%0d directed) under %0d limit settings; %0d results checked.",
                 words_sent, $size(DIRECTED_ROWS), limit_writes, results_checked);
        $display("Inserted %0d, present %0d, duplicate %0d, range %0d, full %0d,",
                 status_tally[sdvq_pkg::ST_INSERTED], status_tally[sdvq_pkg::ST_PRESENT],
                 status_tally[sdvq_pkg::ST_DUPLICATE], status_tally[sdvq_pkg::ST_RANGE],
                 status_tally[sdvq_pkg::ST_FULL]);
        $display("  empty %0d, popped %0d; deepest queue %0d.",
                 status_tally[sdvq_pkg::ST_EMPTY], status_tally[sdvq_pkg::ST_POPPED],
                 deepest_queue);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
